[rtl/core/multicast_source_filter_table_assert.svh]
// assertion macros for the multicast source filter table
`ifndef MULTICAST_SOURCE_FILTER_TABLE_ASSERT_SVH
`define MULTICAST_SOURCE_FILTER_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MSFT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MSFT_ASSERT_IMPL(lbl, ante, cons, msg)
`define MSFT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/core/mcsft_pkg.sv]
package mcsft_pkg;

    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_ADD      = 3'd1;
    localparam logic [2:0] OP_REMOVE   = 3'd2;
    localparam logic [2:0] OP_CLEAR    = 3'd3;
    localparam logic [2:0] OP_SET_MODE = 3'd4;
    localparam logic [2:0] OP_READ     = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [2:0] ST_PRESENT    = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_LIST_FULL  = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX  = 3'd5;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] group_address;
        logic [31:0] source_address;
        logic        req_mode;
        logic [2:0]  source_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic        mode_out;
        logic [3:0]  count_out;
        logic [31:0] source_out;
    } t_out_item;

endpackage

[rtl/core/mcsft_ram.sv]
module mcsft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/core/multicast_source_filter_table.sv]
// channel   | valid        | stall        | payload
// ----------+--------------+--------------+------------------------
// request   | i_in_valid   | o_in_stall   | i_in_data  (t_in_item)
// result    | o_out_valid  | i_out_stall  | o_out_data (t_out_item)
//
// one request at a time: accept in S_IDLE, then the group scan through the record
// memory read port (one record per cycle, ends at the match or at the last group),
// then S_EXEC, then S_RMV compaction for a remove or S_RDSRC for a read, then
// S_DONE loads the result register, waiting there while an earlier result is
// still held under i_out_stall
// synchronous active-low reset clears the record valid bits and the control state
// a new request is taken while a finished result still waits under i_out_stall
`include "multicast_source_filter_table_assert.svh"

module multicast_source_filter_table
    import mcsft_pkg::*;
#(
    parameter int GROUPS            = 16,
    parameter int SOURCES_PER_GROUP = 8
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int GCW    = $clog2(GROUPS + 1);
    localparam int CW     = $clog2(SOURCES_PER_GROUP + 1);
    localparam int SDEPTH = GROUPS * SOURCES_PER_GROUP;
    localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int RW     = 32 + 1 + CW;
    localparam int XW     = (CW > 3) ? CW : 3;

    localparam logic [CW-1:0]  LIST_MAX = CW'(SOURCES_PER_GROUP);
    localparam logic [GCW-1:0] GROUPS_C = GCW'(GROUPS);
    localparam logic [GW-1:0]  LAST_G   = GW'(GROUPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_RMV,
        S_RDSRC,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    t_in_item          r_item, n_item;
    logic [GROUPS-1:0] r_valid, n_valid;
    logic [GCW-1:0]    r_i, n_i;
    logic              r_look, n_look;
    logic [GW-1:0]     r_lidx, n_lidx;
    logic              r_hit, n_hit;
    logic [GW-1:0]     r_e, n_e;
    logic              r_free_ok, n_free_ok;
    logic [GW-1:0]     r_free, n_free;
    logic              r_mode, n_mode;
    logic [CW-1:0]     r_count, n_count;
    logic [SAW-1:0]    r_base, n_base;
    logic [CW-1:0]     r_r, n_r;
    logic [CW-1:0]     r_w, n_w;
    t_out_item         r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              rec_we;
    logic [GW-1:0]     rec_waddr;
    logic [RW-1:0]     rec_wdata;
    logic [GW-1:0]     rec_raddr;
    logic [RW-1:0]     rec_rdata;
    logic              src_we;
    logic [SAW-1:0]    src_waddr;
    logic [31:0]       src_wdata;
    logic [SAW-1:0]    src_raddr;
    logic [31:0]       src_rdata;
    logic              hit_now;
    logic [SAW:0]      src_lim;
    logic              src_in_rec;

    mcsft_ram #(
        .WIDTH (RW),
        .DEPTH (GROUPS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (rec_waddr),
        .i_wdata (rec_wdata),
        .i_raddr (rec_raddr),
        .o_rdata (rec_rdata)
    );

    mcsft_ram #(
        .WIDTH (32),
        .DEPTH (SDEPTH)
    ) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (src_we),
        .i_waddr (src_waddr),
        .i_wdata (src_wdata),
        .i_raddr (src_raddr),
        .o_rdata (src_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign src_lim     = (SAW+1)'(r_base) + (SAW+1)'(SOURCES_PER_GROUP);
    assign src_in_rec  = (src_waddr >= r_base) && ((SAW+1)'(src_waddr) < src_lim);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_valid     = r_valid;
        n_i         = r_i;
        n_look      = r_look;
        n_lidx      = r_lidx;
        n_hit       = r_hit;
        n_e         = r_e;
        n_free_ok   = r_free_ok;
        n_free      = r_free;
        n_mode      = r_mode;
        n_count     = r_count;
        n_base      = r_base;
        n_r         = r_r;
        n_w         = r_w;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        rec_we    = 1'b0;
        rec_waddr = r_e;
        rec_wdata = {r_item.group_address, r_mode, r_count};
        rec_raddr = r_i[GW-1:0];
        src_we    = 1'b0;
        src_waddr = r_base + SAW'(r_w);
        src_wdata = src_rdata;
        src_raddr = r_base + SAW'(r_r);
        hit_now   = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item    = i_in_data;
                    n_i       = '0;
                    n_look    = 1'b0;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                hit_now = r_look && r_valid[r_lidx]
                          && (rec_rdata[RW-1 -: 32] == r_item.group_address);
                if (r_look && !r_valid[r_lidx] && !r_free_ok) begin
                    n_free_ok = 1'b1;
                    n_free    = r_lidx;
                end
                if (hit_now) begin
                    n_hit   = 1'b1;
                    n_e     = r_lidx;
                    n_mode  = rec_rdata[CW];
                    n_count = rec_rdata[CW-1:0];
                    n_base  = SAW'(r_lidx) * SAW'(SOURCES_PER_GROUP);
                    n_state = S_EXEC;
                end else if (r_look && (r_lidx == LAST_G)) begin
                    n_state = S_EXEC;
                end
                if (r_i < GROUPS_C) begin
                    n_i    = r_i + GCW'(1);
                    n_look = 1'b1;
                    n_lidx = r_i[GW-1:0];
                end else begin
                    n_look = 1'b0;
                end
            end
            S_EXEC: begin
                n_res   = '0;
                n_state = S_DONE;
                if (r_item.op == OP_CREATE) begin
                    if (r_hit) begin
                        n_res.status    = ST_PRESENT;
                        n_res.found     = 1'b1;
                        n_res.mode_out  = r_mode;
                        n_res.count_out = 4'(r_count);
                    end else if (!r_free_ok) begin
                        n_res.status = ST_TABLE_FULL;
                    end else begin
                        rec_we           = 1'b1;
                        rec_waddr        = r_free;
                        rec_wdata        = {r_item.group_address, r_item.req_mode, CW'(0)};
                        n_valid[r_free]  = 1'b1;
                        n_res.status     = ST_OK;
                        n_res.mode_out   = r_item.req_mode;
                    end
                end else if (!r_hit) begin
                    n_res.status = ST_NOT_FOUND;
                end else begin
                    n_res.status    = ST_OK;
                    n_res.found     = 1'b1;
                    n_res.mode_out  = r_mode;
                    n_res.count_out = 4'(r_count);
                    case (r_item.op)
                        OP_ADD: begin
                            if (r_count >= LIST_MAX) begin
                                n_res.status = ST_LIST_FULL;
                            end else begin
                                src_we          = 1'b1;
                                src_waddr       = r_base + SAW'(r_count);
                                src_wdata       = r_item.source_address;
                                rec_we          = 1'b1;
                                rec_wdata       = {r_item.group_address, r_mode,
                                                   r_count + CW'(1)};
                                n_res.count_out = 4'(r_count + CW'(1));
                            end
                        end
                        OP_REMOVE: begin
                            n_r     = '0;
                            n_w     = '0;
                            n_look  = 1'b0;
                            n_state = S_RMV;
                        end
                        OP_CLEAR: begin
                            rec_we          = 1'b1;
                            rec_wdata       = {r_item.group_address, r_mode, CW'(0)};
                            n_res.count_out = '0;
                        end
                        OP_SET_MODE: begin
                            rec_we         = 1'b1;
                            rec_wdata      = {r_item.group_address, r_item.req_mode,
                                              r_count};
                            n_res.mode_out = r_item.req_mode;
                        end
                        OP_READ: begin
                            if (XW'(r_item.source_index) >= XW'(r_count)) begin
                                n_res.status = ST_BAD_INDEX;
                            end else begin
                                src_raddr = r_base + SAW'(r_item.source_index);
                                n_state   = S_RDSRC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RMV: begin
                if (r_look && (src_rdata != r_item.source_address)) begin
                    src_we = 1'b1;
                    n_w    = r_w + CW'(1);
                end
                if (r_r != r_count) begin
                    n_r    = r_r + CW'(1);
                    n_look = 1'b1;
                end else begin
                    n_look          = 1'b0;
                    rec_we          = 1'b1;
                    rec_wdata       = {r_item.group_address, r_mode, n_w};
                    n_res.count_out = 4'(n_w);
                    n_state         = S_DONE;
                end
            end
            S_RDSRC: begin
                n_res.source_out = src_rdata;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
        r_item    <= n_item;
        r_i       <= n_i;
        r_look    <= n_look;
        r_lidx    <= n_lidx;
        r_hit     <= n_hit;
        r_e       <= n_e;
        r_free_ok <= n_free_ok;
        r_free    <= n_free;
        r_mode    <= n_mode;
        r_count   <= n_count;
        r_base    <= n_base;
        r_r       <= n_r;
        r_w       <= n_w;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    `MSFT_ASSERT_NEXT(a_accept_scan, i_in_valid && !o_in_stall, r_state == S_SCAN, "no scan")
    `MSFT_ASSERT_IMPL(a_src_in_record, src_we, src_in_rec, "source write outside the record")
    `MSFT_ASSERT_IMPL(a_count_max, rec_we, rec_wdata[CW-1:0] <= LIST_MAX, "count above list size")
    `MSFT_ASSERT_IMPL(a_compact_order, r_state == S_RMV, r_w <= r_r, "write passed read")
    `MSFT_ASSERT_IMPL(a_out_from_done, $rose(o_out_valid), $past(r_state == S_DONE), "not from done")

endmodule

[verif/tb_multicast_source_filter_table.sv]
`timescale 1ns / 1ps

module tb_multicast_source_filter_table;
    import mcsft_pkg::*;

    localparam int GROUPS            = 16;
    localparam int SOURCES_PER_GROUP = 8;
    localparam int RANDOM_ITEMS      = 1100;
    localparam int QUIET_ITEMS       = 150;
    localparam int HOLD_AT_ITEM      = 300;
    localparam int LONG_HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES      = 40;
    localparam int GROUP_POOL        = 18;
    localparam int SOURCE_POOL       = 6;

    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    localparam logic MODE_INCLUDE = 1'b0;
    localparam logic MODE_EXCLUDE = 1'b1;

    typedef struct packed {
        t_in_item  req;
        logic      typed;
        t_out_item reply;
    } t_directed_req;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    logic        rec_valid   [GROUPS];
    logic [31:0] rec_group   [GROUPS];
    logic        rec_mode    [GROUPS];
    logic [3:0]  rec_count   [GROUPS];
    logic [31:0] rec_sources [GROUPS][SOURCES_PER_GROUP];

    t_out_item     replies_due [$];
    t_directed_req directed_reqs [$];
    t_out_item     oldest_reply;
    logic [31:0]   group_pool  [GROUP_POOL];
    logic [31:0]   source_pool [SOURCE_POOL];

    int error_count  = 0;
    bit quiet_phase  = 1'b0;
    bit hold_request = 1'b0;

    multicast_source_filter_table #(
        .GROUPS            (GROUPS),
        .SOURCES_PER_GROUP (SOURCES_PER_GROUP)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_out_item table_reply(input t_in_item req);
        t_out_item res;
        int        hit;
        int        free_slot;
        int        n;
        int        w;
        int        i;
        res = '0;
        res.status = ST_OK;
        hit = -1;
        free_slot = -1;
        for (i = 0; i < GROUPS; i++) begin
            if (hit < 0 && rec_valid[i] && rec_group[i] == req.group_address) hit = i;
            if (free_slot < 0 && !rec_valid[i]) free_slot = i;
        end
        if (req.op == OP_CREATE) begin
            if (hit >= 0) begin
                res.status = ST_PRESENT;
                res.found = 1'b1;
            end else if (free_slot < 0) begin
                res.status = ST_TABLE_FULL;
            end else begin
                rec_valid[free_slot] = 1'b1;
                rec_group[free_slot] = req.group_address;
                rec_mode[free_slot]  = req.req_mode;
                rec_count[free_slot] = 4'd0;
                hit = free_slot;
            end
        end else if (hit < 0) begin
            res.status = ST_NOT_FOUND;
        end else begin
            n = int'(rec_count[hit]);
            res.found = 1'b1;
            case (req.op)
                OP_ADD: begin
                    if (n >= SOURCES_PER_GROUP) begin
                        res.status = ST_LIST_FULL;
                    end else begin
                        rec_sources[hit][n] = req.source_address;
                        rec_count[hit] = 4'(n + 1);
                    end
                end
                OP_REMOVE: begin
                    w = 0;
                    for (i = 0; i < n; i++) begin
                        if (rec_sources[hit][i] != req.source_address) begin
                            rec_sources[hit][w] = rec_sources[hit][i];
                            w++;
                        end
                    end
                    rec_count[hit] = 4'(w);
                end
                OP_CLEAR: rec_count[hit] = 4'd0;
                OP_SET_MODE: rec_mode[hit] = req.req_mode;
                OP_READ: begin
                    if (int'(req.source_index) >= n) res.status = ST_BAD_INDEX;
                    else res.source_out = rec_sources[hit][req.source_index];
                end
                default: ;
            endcase
        end
        if (hit >= 0) begin
            res.mode_out  = rec_mode[hit];
            res.count_out = rec_count[hit];
        end
        return res;
    endfunction

    task automatic add_directed(input t_in_item req, input logic typed, input t_out_item reply);
        t_directed_req row;
        row.req   = req;
        row.typed = typed;
        row.reply = reply;
        directed_reqs = {directed_reqs, row};
    endtask

    // one request transaction, entered and left at a falling edge
    task automatic send_request(input t_in_item req, input logic typed, input t_out_item reply);
        t_out_item predicted;
        t_out_item expected;
        int        gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = table_reply(req);
        expected = typed ? reply : predicted;
        replies_due = {replies_due, expected};
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_in_item req;
        int       pick;
        int       n;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        for (n = 0; n < GROUPS; n++) rec_valid[n] = 1'b0;
        group_pool[0] = 32'h0000_0000;
        group_pool[1] = 32'hffff_ffff;
        for (n = 2; n < GROUP_POOL; n++) group_pool[n] = $urandom;
        source_pool[0] = 32'h0000_0000;
        source_pool[1] = 32'hffff_ffff;
        for (n = 2; n < SOURCE_POOL; n++) source_pool[n] = $urandom;

        add_directed({OP_READ, 32'h0, 32'h0, MODE_INCLUDE, 3'd0}, 1'b1,
                     {ST_NOT_FOUND, 1'b0, MODE_INCLUDE, 4'd0, 32'h0});
        add_directed({OP_UNUSED_7, 32'hffff_ffff, 32'hffff_ffff, MODE_EXCLUDE, 3'd7}, 1'b1,
                     {ST_NOT_FOUND, 1'b0, MODE_INCLUDE, 4'd0, 32'h0});
        add_directed({OP_CREATE, 32'h0, 32'h0, MODE_INCLUDE, 3'd0}, 1'b1,
                     {ST_OK, 1'b0, MODE_INCLUDE, 4'd0, 32'h0});
        add_directed({OP_CREATE, 32'h0, 32'hffff_ffff, MODE_EXCLUDE, 3'd7}, 1'b1,
                     {ST_PRESENT, 1'b1, MODE_INCLUDE, 4'd0, 32'h0});
        add_directed({OP_CREATE, 32'hffff_ffff, 32'h0, MODE_EXCLUDE, 3'd0}, 1'b1,
                     {ST_OK, 1'b0, MODE_EXCLUDE, 4'd0, 32'h0});
        add_directed({OP_READ, 32'h0, 32'h0, MODE_INCLUDE, 3'd0}, 1'b1,
                     {ST_BAD_INDEX, 1'b1, MODE_INCLUDE, 4'd0, 32'h0});
        add_directed({OP_ADD, 32'h0, 32'h0, MODE_INCLUDE, 3'd0}, 1'b1,
                     {ST_OK, 1'b1, MODE_INCLUDE, 4'd1, 32'h0});
        add_directed({OP_ADD, 32'h0, 32'hffff_ffff, MODE_INCLUDE, 3'd0}, 1'b1,
                     {ST_OK, 1'b1, MODE_INCLUDE, 4'd2, 32'h0});
        add_directed({OP_ADD, 32'h0, 32'hffff_ffff, MODE_INCLUDE, 3'd0}, 1'b0, '0);
        add_directed({OP_ADD, 32'h0, 32'ha5a5_a5a5, MODE_INCLUDE, 3'd0}, 1'b0, '0);
        add_directed({OP_ADD, 32'h0, 32'h5a5a_5a5a, MODE_INCLUDE, 3'd0}, 1'b0, '0);
        add_directed({OP_ADD, 32'h0, 32'hffff_ffff, MODE_INCLUDE, 3'd0}, 1'b0, '0);
        add_directed({OP_ADD, 32'h0, 32'h0000_0001, MODE_INCLUDE, 3'd0}, 1'b0, '0);
        add_directed({OP_ADD, 32'h0, 32'h8000_0000, MODE_INCLUDE, 3'd0}, 1'b0, '0);
        add_directed({OP_ADD, 32'h0, 32'h1234_5678, MODE_INCLUDE, 3'd0}, 1'b1,
                     {ST_LIST_FULL, 1'b1, MODE_INCLUDE, 4'd8, 32'h0});
        add_directed({OP_READ, 32'h0, 32'h0, MODE_INCLUDE, 3'd7}, 1'b0, '0);
        add_directed({OP_READ, 32'h0, 32'h0, MODE_INCLUDE, 3'd1}, 1'b0, '0);
        add_directed({OP_REMOVE, 32'h0, 32'hffff_ffff, MODE_INCLUDE, 3'd0}, 1'b0, '0);
        add_directed({OP_REMOVE, 32'h0, 32'hdead_beef, MODE_INCLUDE, 3'd0}, 1'b0, '0);
        add_directed({OP_READ, 32'h0, 32'h0, MODE_INCLUDE, 3'd5}, 1'b0, '0);
        add_directed({OP_SET_MODE, 32'h0, 32'h0, MODE_EXCLUDE, 3'd0}, 1'b0, '0);
        add_directed({OP_UNUSED_6, 32'h0, 32'h0, MODE_INCLUDE, 3'd0}, 1'b0, '0);
        add_directed({OP_CLEAR, 32'hffff_ffff, 32'h0, MODE_INCLUDE, 3'd0}, 1'b0, '0);
        add_directed({OP_SET_MODE, 32'hffff_ffff, 32'h0, MODE_INCLUDE, 3'd0}, 1'b0, '0);
        add_directed({OP_CLEAR, 32'h0, 32'h0, MODE_INCLUDE, 3'd0}, 1'b0, '0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_reqs[k])
            send_request(directed_reqs[k].req, directed_reqs[k].typed, directed_reqs[k].reply);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT_ITEM) hold_request = 1'b1;
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 14) req.op = OP_CREATE;
            else if (pick < 48) req.op = OP_ADD;
            else if (pick < 62) req.op = OP_REMOVE;
            else if (pick < 82) req.op = OP_READ;
            else if (pick < 86) req.op = OP_CLEAR;
            else if (pick < 95) req.op = OP_SET_MODE;
            else if (pick < 97) req.op = OP_UNUSED_6;
            else req.op = OP_UNUSED_7;
            if ($urandom_range(0, 99) < 8) req.group_address = $urandom;
            else req.group_address = group_pool[$urandom_range(0, GROUP_POOL - 1)];
            if ($urandom_range(0, 9) < 7)
                req.source_address = source_pool[$urandom_range(0, SOURCE_POOL - 1)];
            else
                req.source_address = $urandom;
            req.req_mode     = 1'($urandom_range(0, 1));
            req.source_index = 3'($urandom_range(0, 7));
            send_request(req, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // receiver back-pressure: short random bursts plus one long hold-off
    initial begin : result_stall
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                $error("result transaction with nothing pending: %h", o_out_data);
                error_count++;
            end else begin
                oldest_reply = replies_due.pop_front();
                if (o_out_data.status !== oldest_reply.status) begin
                    $error("status: expected %0d, got %0d",
                           oldest_reply.status, o_out_data.status);
                    error_count++;
                end
                if (o_out_data.found !== oldest_reply.found) begin
                    $error("found: expected %0d, got %0d",
                           oldest_reply.found, o_out_data.found);
                    error_count++;
                end
                if (o_out_data.mode_out !== oldest_reply.mode_out) begin
                    $error("mode_out: expected %0d, got %0d",
                           oldest_reply.mode_out, o_out_data.mode_out);
                    error_count++;
                end
                if (o_out_data.count_out !== oldest_reply.count_out) begin
                    $error("count_out: expected %0d, got %0d",
                           oldest_reply.count_out, o_out_data.count_out);
                    error_count++;
                end
                if (o_out_data.source_out !== oldest_reply.source_out) begin
                    $error("source_out: expected %h, got %h",
                           oldest_reply.source_out, o_out_data.source_out);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
